// File: design/rfd_pkg.sv
package rfd_pkg;

    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] SYNC_0 = 8'h6e;
    localparam logic [BYTE_W-1:0] SYNC_1 = 8'h53;
    localparam logic [BYTE_W-1:0] SYNC_2 = 8'h53;
    localparam logic [BYTE_W-1:0] SYNC_3 = 8'h54;
    localparam logic [BYTE_W-1:0] SYNC_SUM = BYTE_W'(SYNC_0 + SYNC_1 + SYNC_2 + SYNC_3);

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] rx_byte;
    } t_stage;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] byte_index;
        logic              good;
        logic [BYTE_W-1:0] ver_major;
        logic [BYTE_W-1:0] ver_minor;
        logic [BYTE_W-1:0] src_addr;
        logic [BYTE_W-1:0] dst_addr;
        logic [BYTE_W-1:0] packet_type;
        logic [BYTE_W-1:0] payload_len;
    } t_res_data;

    typedef struct packed {
        logic      valid;
        t_res_data data;
    } t_res;

    function automatic logic [BYTE_W-1:0] sync_expect(input logic [1:0] pos);
        logic [BYTE_W-1:0] r;
        unique case (pos)
            2'd0:    r = SYNC_0;
            2'd1:    r = SYNC_1;
            2'd2:    r = SYNC_2;
            default: r = SYNC_3;
        endcase
        return r;
    endfunction

endpackage

// File: design/rfd_if.sv
interface rfd_in_if;
    import rfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

interface rfd_out_if;
    import rfd_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] byte_index;
    logic              good;
    logic [BYTE_W-1:0] ver_major;
    logic [BYTE_W-1:0] ver_minor;
    logic [BYTE_W-1:0] src_addr;
    logic [BYTE_W-1:0] dst_addr;
    logic [BYTE_W-1:0] packet_type;
    logic [BYTE_W-1:0] payload_len;

    modport source(output valid, output kind, output data, output byte_index, output good,
                   output ver_major, output ver_minor, output src_addr,
                   output dst_addr, output packet_type, output payload_len, input ready);
    modport sink(input valid, input kind, input data, input byte_index, input good,
                 input ver_major, input ver_minor, input src_addr,
                 input dst_addr, input packet_type, input payload_len, output ready);
endinterface

// File: design/rfd_in_reg.sv
module rfd_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rfd_in_if.sink          i_rx,
    input  logic            i_adv,
    output rfd_pkg::t_stage o_stage
);
    import rfd_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              w_take;

    assign i_rx.ready = !r_valid || i_adv;
    assign w_take     = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_stage.valid   = r_valid;
    assign o_stage.rx_byte = r_byte;

endmodule

// File: design/rfd_parser.sv
module rfd_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rfd_pkg::t_stage i_stage,
    input  logic            i_adv,
    output rfd_pkg::t_res   o_res
);
    import rfd_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_VMAJ  = 4'd1,
        PH_VMIN  = 4'd2,
        PH_SRC   = 4'd3,
        PH_DST   = 4'd4,
        PH_TYPE  = 4'd5,
        PH_LEN   = 4'd6,
        PH_PAY   = 4'd7,
        PH_CHECK = 4'd8,
        PH_END   = 4'd9
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [1:0]        r_sync, n_sync;
    logic [BYTE_W-1:0] r_vmaj, n_vmaj;
    logic [BYTE_W-1:0] r_vmin, n_vmin;
    logic [BYTE_W-1:0] r_src, n_src;
    logic [BYTE_W-1:0] r_dst, n_dst;
    logic [BYTE_W-1:0] r_type, n_type;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_pay, n_pay;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_check, n_check;

    logic              w_step;
    logic [BYTE_W-1:0] w_b;
    logic [BYTE_W-1:0] w_pay_inc;
    t_res              w_res;

    assign w_step    = i_stage.valid && i_adv;
    assign w_b       = i_stage.rx_byte;
    assign w_pay_inc = r_pay + 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_sync  = r_sync;
        n_vmaj  = r_vmaj;
        n_vmin  = r_vmin;
        n_src   = r_src;
        n_dst   = r_dst;
        n_type  = r_type;
        n_len   = r_len;
        n_pay   = r_pay;
        n_sum   = r_sum;
        n_check = r_check;
        w_res   = '0;
        unique case (r_phase)
            PH_VMAJ: begin
                n_vmaj  = w_b;
                n_sum   = r_sum + w_b;
                n_phase = PH_VMIN;
            end
            PH_VMIN: begin
                n_vmin  = w_b;
                n_sum   = r_sum + w_b;
                n_phase = PH_SRC;
            end
            PH_SRC: begin
                n_src   = w_b;
                n_sum   = r_sum + w_b;
                n_phase = PH_DST;
            end
            PH_DST: begin
                n_dst   = w_b;
                n_sum   = r_sum + w_b;
                n_phase = PH_TYPE;
            end
            PH_TYPE: begin
                n_type  = w_b;
                n_sum   = r_sum + w_b;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len   = w_b;
                n_sum   = r_sum + w_b;
                n_pay   = '0;
                n_phase = (w_b == '0) ? PH_CHECK : PH_PAY;
            end
            PH_PAY: begin
                w_res.valid           = 1'b1;
                w_res.data.kind       = KIND_PAYLOAD;
                w_res.data.data       = w_b;
                w_res.data.byte_index = r_pay;
                n_sum                 = r_sum + w_b;
                n_pay                 = w_pay_inc;
                if (w_pay_inc >= r_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_check = w_b;
                n_phase = PH_END;
            end
            PH_END: begin
                w_res.valid            = 1'b1;
                w_res.data.kind        = KIND_DONE;
                w_res.data.good        = (w_b == '0) && (r_check == r_sum);
                w_res.data.ver_major   = r_vmaj;
                w_res.data.ver_minor   = r_vmin;
                w_res.data.src_addr    = r_src;
                w_res.data.dst_addr    = r_dst;
                w_res.data.packet_type = r_type;
                w_res.data.payload_len = r_len;
                n_phase                = PH_HUNT;
                n_sync                 = '0;
            end
            default: begin
                n_phase = PH_HUNT;
                if (w_b == sync_expect(r_sync)) begin
                    if (r_sync == 2'd3) begin
                        n_sync  = '0;
                        n_phase = PH_VMAJ;
                        n_sum   = SYNC_SUM;
                    end else begin
                        n_sync = r_sync + 1'b1;
                    end
                end else begin
                    n_sync = (w_b == SYNC_0) ? 2'd1 : 2'd0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_sync  <= '0;
            r_vmaj  <= '0;
            r_vmin  <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_type  <= '0;
            r_len   <= '0;
            r_pay   <= '0;
            r_sum   <= '0;
            r_check <= '0;
        end else if (w_step) begin
            r_phase <= n_phase;
            r_sync  <= n_sync;
            r_vmaj  <= n_vmaj;
            r_vmin  <= n_vmin;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_type  <= n_type;
            r_len   <= n_len;
            r_pay   <= n_pay;
            r_sum   <= n_sum;
            r_check <= n_check;
        end
    end

    assign o_res = w_res;

    a_done_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_phase == PH_END) |=> (r_phase == PH_HUNT && r_sync == 2'd0))
        else $error("done byte did not return to hunt");

    a_last_pay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_phase == PH_PAY && w_pay_inc >= r_len) |=> (r_phase == PH_CHECK))
        else $error("last payload byte did not move to checksum");

    a_pay_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_phase == PH_PAY) |=> (r_pay == $past(r_pay) + 1'b1))
        else $error("payload index did not advance");

endmodule

// File: design/rfd_out_reg.sv
module rfd_out_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  rfd_pkg::t_res i_res,
    output logic          o_adv,
    rfd_out_if.source     o_res
);
    import rfd_pkg::*;

    logic      r_valid;
    t_res_data r_data;

    assign o_adv = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_step && i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_step && i_res.valid) begin
            r_data <= i_res.data;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.kind        = r_data.kind;
    assign o_res.data        = r_data.data;
    assign o_res.byte_index  = r_data.byte_index;
    assign o_res.good        = r_data.good;
    assign o_res.ver_major   = r_data.ver_major;
    assign o_res.ver_minor   = r_data.ver_minor;
    assign o_res.src_addr    = r_data.src_addr;
    assign o_res.dst_addr    = r_data.dst_addr;
    assign o_res.packet_type = r_data.packet_type;
    assign o_res.payload_len = r_data.payload_len;

endmodule

// File: design/rf_packet_deframer_top.sv
// path: a byte accepted into the input register has its result, if any, registered in the output register as it leaves
// throughput: one byte per cycle; the phase state updates once per byte as it leaves the input
// register, and both stages stall together only while a result waits to be taken
// reset: synchronous active low; empties both stages and returns to sync hunt with all state zero
module rf_packet_deframer_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rfd_in_if.sink    i_rx,
    rfd_out_if.source o_res
);
    import rfd_pkg::*;

    t_stage w_stage;
    t_res   w_res;
    logic   w_adv;
    logic   w_step;

    assign w_step = w_stage.valid && w_adv;

    rfd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_adv   (w_adv),
        .o_stage (w_stage)
    );

    rfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_stage),
        .i_adv   (w_adv),
        .o_res   (w_res)
    );

    rfd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_res   (w_res),
        .o_adv   (w_adv),
        .o_res   (o_res)
    );

endmodule

// File: sim/tb_rf_packet_deframer_top.sv
module tb_rf_packet_deframer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rfd_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int BYTES_TARGET  = 750;
    localparam int HOLD_AT_BYTES = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_PRINTED   = 50;

    localparam t_res_data NO_RES = '0;
    localparam logic [BYTE_W-1:0] SYNC_WORD [4] = '{SYNC_0, SYNC_1, SYNC_2, SYNC_3};

    typedef enum logic [3:0] {
        FR_HUNT, FR_VER_MAJOR, FR_VER_MINOR, FR_SRC, FR_DST, FR_TYPE, FR_LEN,
        FR_PAYLOAD, FR_CHECK, FR_END
    } t_frame_phase;

    typedef struct {
        logic [BYTE_W-1:0] rx;
        bit                pinned;
        t_res_data         want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    rfd_in_if  rx_if ();
    rfd_out_if res_if ();

    rf_packet_deframer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    // deframer state mirror
    t_frame_phase      fr_phase;
    logic [1:0]        sync_cnt;
    logic [BYTE_W-1:0] hdr_ver_major, hdr_ver_minor, hdr_src, hdr_dst, hdr_type, hdr_len;
    logic [BYTE_W-1:0] pay_cnt, sum_acc, sum_rx;

    t_res_data expected_results [$];
    t_stim_row directed_rows [26];

    int  mismatches;
    int  bytes_sent;
    int  cycles;
    int  payload_seen, done_good_seen, done_bad_seen, deepest_index;
    bit  tx_calm;
    bit  hold_done;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output t_res_data res);
        bit emitted;
        emitted = 1'b0;
        res = '0;
        if (fr_phase >= FR_VER_MAJOR && fr_phase <= FR_PAYLOAD)
            sum_acc += b;
        case (fr_phase)
            FR_VER_MAJOR: begin
                hdr_ver_major = b;
                fr_phase = FR_VER_MINOR;
            end
            FR_VER_MINOR: begin
                hdr_ver_minor = b;
                fr_phase = FR_SRC;
            end
            FR_SRC: begin
                hdr_src = b;
                fr_phase = FR_DST;
            end
            FR_DST: begin
                hdr_dst = b;
                fr_phase = FR_TYPE;
            end
            FR_TYPE: begin
                hdr_type = b;
                fr_phase = FR_LEN;
            end
            FR_LEN: begin
                hdr_len = b;
                pay_cnt = '0;
                fr_phase = (b == 8'd0) ? FR_CHECK : FR_PAYLOAD;
            end
            FR_PAYLOAD: begin
                res.kind = KIND_PAYLOAD;
                res.data = b;
                res.byte_index = pay_cnt;
                pay_cnt++;
                if (pay_cnt >= hdr_len)
                    fr_phase = FR_CHECK;
                emitted = 1'b1;
            end
            FR_CHECK: begin
                sum_rx = b;
                fr_phase = FR_END;
            end
            FR_END: begin
                res.kind = KIND_DONE;
                res.good = (b == 8'd0) && (sum_rx == sum_acc);
                res.ver_major = hdr_ver_major;
                res.ver_minor = hdr_ver_minor;
                res.src_addr = hdr_src;
                res.dst_addr = hdr_dst;
                res.packet_type = hdr_type;
                res.payload_len = hdr_len;
                fr_phase = FR_HUNT;
                sync_cnt = '0;
                emitted = 1'b1;
            end
            default: begin
                fr_phase = FR_HUNT;
                if (b == SYNC_WORD[sync_cnt]) begin
                    if (sync_cnt == 2'd3) begin
                        sync_cnt = '0;
                        fr_phase = FR_VER_MAJOR;
                        sum_acc = SYNC_SUM;
                    end else begin
                        sync_cnt++;
                    end
                end else begin
                    sync_cnt = (b == SYNC_0) ? 2'd1 : 2'd0;
                end
            end
        endcase
        return emitted;
    endfunction

    function automatic t_res_data done_rec(input logic good, input logic [BYTE_W-1:0] vmaj,
                                           input logic [BYTE_W-1:0] vmin,
                                           input logic [BYTE_W-1:0] src,
                                           input logic [BYTE_W-1:0] dst,
                                           input logic [BYTE_W-1:0] ptype,
                                           input logic [BYTE_W-1:0] len);
        t_res_data r;
        r = '0;
        r.kind = KIND_DONE;
        r.good = good;
        r.ver_major = vmaj;
        r.ver_minor = vmin;
        r.src_addr = src;
        r.dst_addr = dst;
        r.packet_type = ptype;
        r.payload_len = len;
        return r;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit pinned, input t_res_data want);
        t_res_data res;
        int        gap;
        int        roll;
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        bytes_sent++;
        if (deframe_byte(b, res))
            expected_results.push_back(pinned ? want : res);
        else if (pinned)
            expected_results.push_back(want);
        gap = 0;
        if (!tx_calm) begin
            roll = $urandom_range(0, 99);
            if (roll >= 95)
                gap = $urandom_range(8, 40);
            else if (roll >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_packet(input int len_force);
        logic [BYTE_W-1:0] pkt [$];
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] sum;
        int                cut;
        pkt = '{SYNC_0, SYNC_1, SYNC_2, SYNC_3};
        repeat (5) pkt.push_back(8'($urandom_range(0, 255)));
        if (len_force >= 0)
            len = 8'(len_force);
        else if ($urandom_range(0, 9) == 0)
            len = 8'($urandom_range(9, 40));
        else
            len = 8'($urandom_range(0, 8));
        pkt.push_back(len);
        // sync bytes inside the payload must not restart the hunt
        repeat (len)
            pkt.push_back(($urandom_range(0, 7) == 0) ? SYNC_WORD[$urandom_range(0, 3)]
                                                      : 8'($urandom_range(0, 255)));
        sum = '0;
        foreach (pkt[i]) sum += pkt[i];
        pkt.push_back(($urandom_range(0, 99) < 85) ? sum : 8'($urandom_range(0, 255)));
        pkt.push_back(($urandom_range(0, 99) < 85) ? 8'h00 : 8'($urandom_range(1, 255)));
        cut = pkt.size();
        if ($urandom_range(0, 99) < 8)
            cut = $urandom_range(1, pkt.size() - 1);
        tx_calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < cut; i++)
            send_byte(pkt[i], 1'b0, NO_RES);
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    task automatic compare_field(input string name, input logic [BYTE_W-1:0] got_v,
                                 input logic [BYTE_W-1:0] want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("%s got %02h want %02h", name, got_v, want_v));
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_res_data got, want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.kind, res_if.data, res_if.byte_index, res_if.good,
                    res_if.ver_major, res_if.ver_minor, res_if.src_addr,
                    res_if.dst_addr, res_if.packet_type, res_if.payload_len};
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
            end else begin
                want = expected_results.pop_front();
                compare_field("kind", BYTE_W'(got.kind), BYTE_W'(want.kind));
                compare_field("data", got.data, want.data);
                compare_field("byte_index", got.byte_index, want.byte_index);
                compare_field("good", BYTE_W'(got.good), BYTE_W'(want.good));
                compare_field("ver_major", got.ver_major, want.ver_major);
                compare_field("ver_minor", got.ver_minor, want.ver_minor);
                compare_field("src_addr", got.src_addr, want.src_addr);
                compare_field("dst_addr", got.dst_addr, want.dst_addr);
                compare_field("packet_type", got.packet_type, want.packet_type);
                compare_field("payload_len", got.payload_len, want.payload_len);
                if (want.kind == KIND_PAYLOAD) begin
                    payload_seen++;
                    if (int'(want.byte_index) > deepest_index)
                        deepest_index = int'(want.byte_index);
                end else if (want.good) begin
                    done_good_seen++;
                end else begin
                    done_bad_seen++;
                end
            end
        end
    end

    // receiver side
    initial begin
        int stall_left;
        int rx_cycles;
        int roll;
        stall_left = 0;
        rx_cycles = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycles++;
            if (!hold_done && bytes_sent >= HOLD_AT_BYTES) begin
                // long hold-off so the block backs up into its input
                hold_done = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if ((rx_cycles % 512) < 384) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 2)
                        stall_left = $urandom_range(10, 40);
                    else if (roll < 20)
                        stall_left = $urandom_range(1, 3);
                end
            end
        end
    end

    // sender side
    initial begin
        int roll;
        directed_rows = '{
            // zero length packet, extreme header bytes, good
            '{SYNC_0, 1'b0, NO_RES}, '{SYNC_1, 1'b0, NO_RES},
            '{SYNC_2, 1'b0, NO_RES}, '{SYNC_3, 1'b0, NO_RES},
            '{8'hff, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
            '{8'ha5, 1'b0, NO_RES}, '{8'h5a, 1'b0, NO_RES},
            '{8'h01, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
            '{8'h67, 1'b0, NO_RES},
            '{8'h00, 1'b1, done_rec(1'b1, 8'hff, 8'h00, 8'ha5, 8'h5a, 8'h01, 8'h00)},
            // stray sync start, then one byte payload with bad checksum and end byte
            '{SYNC_0, 1'b0, NO_RES},
            '{SYNC_0, 1'b0, NO_RES}, '{SYNC_1, 1'b0, NO_RES},
            '{SYNC_2, 1'b0, NO_RES}, '{SYNC_3, 1'b0, NO_RES},
            '{8'h00, 1'b0, NO_RES}, '{8'hff, 1'b0, NO_RES},
            '{8'h00, 1'b0, NO_RES}, '{8'hff, 1'b0, NO_RES},
            '{8'hff, 1'b0, NO_RES}, '{8'h01, 1'b0, NO_RES},
            '{8'hff, 1'b1, '{kind: KIND_PAYLOAD, data: 8'hff, default: '0}},
            '{8'h00, 1'b0, NO_RES},
            '{8'hff, 1'b1, done_rec(1'b0, 8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 8'h01)}
        };
        fr_phase = FR_HUNT;
        sync_cnt = '0;
        {hdr_ver_major, hdr_ver_minor, hdr_src, hdr_dst, hdr_type, hdr_len} = '0;
        {pay_cnt, sum_acc, sum_rx} = '0;
        i_rst_n <= 1'b0;
        rx_if.valid <= 1'b0;
        rx_if.rx_byte <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_calm = 1'b0;
        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].pinned, directed_rows[i].want);

        // one full length packet reaches the last payload index unless the random cut truncates it
        send_random_packet(255);
        while (bytes_sent < BYTES_TARGET) begin
            roll = $urandom_range(0, 99);
            tx_calm = 1'b0;
            if (roll < 20) begin
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RES);
            end else if (roll < 28) begin
                send_byte(SYNC_0, 1'b0, NO_RES);
                send_byte(SYNC_1, 1'b0, NO_RES);
            end
            send_random_packet(-1);
        end
        rx_if.valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("sent %0d bytes; checked %0d payload transfers, %0d good and %0d bad packets",
                 bytes_sent, payload_seen, done_good_seen, done_bad_seen);
        $display("deepest payload index %0d, receiver hold-off %0s, %0d mismatches",
                 deepest_index, hold_done ? "done" : "missed", mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
